### rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg: shared types and constants of the serial command link controller
// Request and result records, link phase codes, request kinds, status codes
// and the command length lookup.
// ----------------------------------------------------------------------------
package scl_pkg;

   // field widths
   localparam int KIND_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 4;
   localparam int LENGTH_W = 5;
   localparam int STATUS_W = 2;
   localparam int PHASE_W  = 3;
   localparam int COUNT_W  = 4;
   localparam int WAIT_W   = 8;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEND  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FREE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

   // link phases
   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_OPCODE  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PARAM   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CHECK   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DATA    = 3'd4;
   localparam logic [PHASE_W-1:0] PH_TRAILER = 3'd5;
   localparam logic [PHASE_W-1:0] PH_ERRWAIT = 3'd6;

   // command status codes
   localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAME  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ERROR = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic                line_low;
      logic [BYTE_W-1:0]   rx_byte;
      logic [INDEX_W-1:0]  index;
      logic [BYTE_W-1:0]   tx_byte;
      logic [LENGTH_W-1:0] send_length;
      logic                send_with_checksum;
   } scl_req_type;

   typedef struct packed {
      logic                tx_valid;
      logic [BYTE_W-1:0]   tx_data;
      logic                line_release;
      logic [STATUS_W-1:0] cmd_status;
      logic [BYTE_W-1:0]   read_data;
      logic                send_accepted;
      logic                send_busy;
   } scl_rsp_type;

   // command length in bytes, opcode included, by opcode low nibble
   function automatic logic [COUNT_W-1:0] length_by_nibble(input logic [3:0] nibble);
      logic [COUNT_W-1:0] len;
      case (nibble)
         4'h1:    len = 4'd2;
         4'h4:    len = 4'd12;
         4'h5:    len = 4'd2;
         4'h8:    len = 4'd4;
         4'hD:    len = 4'd2;
         default: len = 4'd1;
      endcase
      return len;
   endfunction

endpackage

### rtl/scl_channels_if.sv
// ----------------------------------------------------------------------------
// scl channels: request and result handshake interfaces
// Valid/ready channels carrying the link request fields and the result fields.
// ----------------------------------------------------------------------------
interface scl_req_if;
   logic                          valid;
   logic                          ready;
   logic [scl_pkg::KIND_W-1:0]    kind;
   logic                          line_low;
   logic [scl_pkg::BYTE_W-1:0]    rx_byte;
   logic [scl_pkg::INDEX_W-1:0]   index;
   logic [scl_pkg::BYTE_W-1:0]    tx_byte;
   logic [scl_pkg::LENGTH_W-1:0]  send_length;
   logic                          send_with_checksum;

   modport source (output valid, kind, line_low, rx_byte, index, tx_byte, send_length,
                   send_with_checksum, input ready);
   modport sink   (input valid, kind, line_low, rx_byte, index, tx_byte, send_length,
                   send_with_checksum, output ready);
endinterface

interface scl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          tx_valid;
   logic [scl_pkg::BYTE_W-1:0]    tx_data;
   logic                          line_release;
   logic [scl_pkg::STATUS_W-1:0]  cmd_status;
   logic [scl_pkg::BYTE_W-1:0]    read_data;
   logic                          send_accepted;
   logic                          send_busy;

   modport source (output valid, tx_valid, tx_data, line_release, cmd_status, read_data,
                   send_accepted, send_busy, input ready);
   modport sink   (input valid, tx_valid, tx_data, line_release, cmd_status, read_data,
                   send_accepted, send_busy, output ready);
endinterface

### rtl/serial_command_link_controller.sv
// ----------------------------------------------------------------------------
// serial_command_link_controller: half-duplex command link engine
// A result passes the request register and then the result register, and
// is held while the result channel stalls.
// Throughput: one request per cycle unless the result channel stalls, set by
// the single pass through the link engine between the request and result registers.
// Reset (synchronous): link idle, counters and command buffer cleared; the
// reply buffer holds no defined value until loaded.
// ----------------------------------------------------------------------------
module serial_command_link_controller #(
   parameter int CMD_DEPTH        = 12,
   parameter int REPLY_DEPTH      = 16,
   parameter int ERROR_WAIT_TICKS = 128
) (
   input logic      clock,
   input logic      reset,
   scl_req_if.sink  req_chan,
   scl_rsp_if.source rsp_chan
);
   import scl_pkg::*;

   logic        in_valid_ff;
   scl_req_type in_item_ff;
   logic        out_valid_ff;
   scl_rsp_type out_item_ff;
   scl_req_type req_item;
   scl_rsp_type result;
   logic        advance;
   logic        req_fire;

   // pack incoming request fields
   assign req_item.kind               = req_chan.kind;
   assign req_item.line_low           = req_chan.line_low;
   assign req_item.rx_byte            = req_chan.rx_byte;
   assign req_item.index              = req_chan.index;
   assign req_item.tx_byte            = req_chan.tx_byte;
   assign req_item.send_length        = req_chan.send_length;
   assign req_item.send_with_checksum = req_chan.send_with_checksum;

   // pipeline flow control
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
   end

   scl_link_engine #(
      .CMD_DEPTH        (CMD_DEPTH),
      .REPLY_DEPTH      (REPLY_DEPTH),
      .ERROR_WAIT_TICKS (ERROR_WAIT_TICKS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   // drive result channel
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.tx_valid      = out_item_ff.tx_valid;
   assign rsp_chan.tx_data       = out_item_ff.tx_data;
   assign rsp_chan.line_release  = out_item_ff.line_release;
   assign rsp_chan.cmd_status    = out_item_ff.cmd_status;
   assign rsp_chan.read_data     = out_item_ff.read_data;
   assign rsp_chan.send_accepted = out_item_ff.send_accepted;
   assign rsp_chan.send_busy     = out_item_ff.send_busy;

endmodule

### rtl/scl_link_engine.sv
// ----------------------------------------------------------------------------
// scl_link_engine: link state, command and reply buffers
// Computes the result of one request from the current state and commits the
// new state when the request advances.
// ----------------------------------------------------------------------------
module scl_link_engine #(
   parameter int CMD_DEPTH        = 12,
   parameter int REPLY_DEPTH      = 16,
   parameter int ERROR_WAIT_TICKS = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  scl_pkg::scl_req_type item,
   output scl_pkg::scl_rsp_type result
);
   import scl_pkg::*;

   localparam int CIDX_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int RIDX_W = (REPLY_DEPTH > 1) ? $clog2(REPLY_DEPTH) : 1;
   localparam logic [LENGTH_W-1:0] CMD_LIMIT   = LENGTH_W'(CMD_DEPTH);
   localparam logic [LENGTH_W-1:0] REPLY_LIMIT = LENGTH_W'(REPLY_DEPTH);
   localparam logic [WAIT_W-1:0]   WAIT_LOAD   = WAIT_W'(ERROR_WAIT_TICKS);

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [COUNT_W-1:0]  expected_length_ff, expected_length_in;
   logic [BYTE_W-1:0]   running_sum_ff, running_sum_in;
   logic [COUNT_W-1:0]  rx_count_ff, rx_count_in;
   logic [LENGTH_W-1:0] tx_pointer_ff, tx_pointer_in;
   logic [LENGTH_W-1:0] tx_remaining_ff, tx_remaining_in;
   logic [WAIT_W-1:0]   error_wait_ff, error_wait_in;
   logic [STATUS_W-1:0] status_code_ff, status_code_in;
   logic [BYTE_W-1:0]   previous_opcode_ff, previous_opcode_in;
   logic                send_pending_ff, send_pending_in;
   logic                trailer_wanted_ff, trailer_wanted_in;
   logic                status_pending_ff, status_pending_in;

   logic [BYTE_W-1:0]   command_ff [CMD_DEPTH];
   logic [BYTE_W-1:0]   reply_ff [REPLY_DEPTH];

   logic                cmd_we;
   logic [CIDX_W-1:0]   cmd_waddr;
   logic [BYTE_W-1:0]   cmd_wdata;
   logic                reply_we;
   logic [BYTE_W-1:0]   reply_byte;
   logic [BYTE_W-1:0]   read_byte;
   logic [COUNT_W-1:0]  opcode_length;

   // buffer read ports
   assign reply_byte = (tx_pointer_ff < REPLY_LIMIT) ? reply_ff[tx_pointer_ff[RIDX_W-1:0]]
                                                     : '0;
   assign read_byte  = ({1'b0, item.index} < CMD_LIMIT) ? command_ff[item.index[CIDX_W-1:0]]
                                                        : '0;
   assign opcode_length = length_by_nibble(item.rx_byte[3:0]);
   assign reply_we = (item.kind == KIND_LOAD) && ({1'b0, item.index} < REPLY_LIMIT);

   // next state and result for one request
   always_comb begin
      phase_in           = phase_ff;
      expected_length_in = expected_length_ff;
      running_sum_in     = running_sum_ff;
      rx_count_in        = rx_count_ff;
      tx_pointer_in      = tx_pointer_ff;
      tx_remaining_in    = tx_remaining_ff;
      error_wait_in      = error_wait_ff;
      status_code_in     = status_code_ff;
      previous_opcode_in = previous_opcode_ff;
      send_pending_in    = send_pending_ff;
      trailer_wanted_in  = trailer_wanted_ff;
      status_pending_in  = status_pending_ff;
      cmd_we             = 1'b0;
      cmd_waddr          = '0;
      cmd_wdata          = item.rx_byte;
      result             = '0;

      case (item.kind)
         KIND_TICK: begin
            case (phase_ff)
               PH_IDLE: begin
                  if (send_pending_ff) begin
                     tx_pointer_in  = '0;
                     running_sum_in = '0;
                     phase_in       = PH_DATA;
                  end else if (item.line_low) begin
                     rx_count_in    = '0;
                     running_sum_in = '0;
                     phase_in       = PH_OPCODE;
                  end
               end
               PH_OPCODE: begin
                  if (item.rx_byte == '0) begin
                     error_wait_in = WAIT_LOAD;
                     phase_in      = PH_ERRWAIT;
                  end else begin
                     cmd_we             = 1'b1;
                     running_sum_in     = item.rx_byte;
                     rx_count_in        = COUNT_W'(1);
                     expected_length_in = opcode_length;
                     phase_in = (opcode_length <= COUNT_W'(1)) ? PH_CHECK : PH_PARAM;
                  end
               end
               PH_PARAM: begin
                  if (item.line_low) begin
                     cmd_we         = ({1'b0, rx_count_ff} < CMD_LIMIT);
                     cmd_waddr      = rx_count_ff[CIDX_W-1:0];
                     running_sum_in = running_sum_ff + item.rx_byte;
                     rx_count_in    = rx_count_ff + COUNT_W'(1);
                     if (rx_count_in >= expected_length_ff) begin
                        phase_in = PH_CHECK;
                     end
                  end
               end
               PH_CHECK: begin
                  if (item.line_low) begin
                     status_pending_in = 1'b1;
                     if (~item.rx_byte == running_sum_ff) begin
                        if (command_ff[0] == previous_opcode_ff) begin
                           status_code_in = ST_SAME;
                        end else begin
                           status_code_in     = ST_NEW;
                           previous_opcode_in = command_ff[0];
                        end
                     end else begin
                        status_code_in     = ST_ERROR;
                        previous_opcode_in = '0;
                     end
                     running_sum_in = '0;
                     phase_in       = PH_IDLE;
                  end
               end
               PH_DATA: begin
                  if (!item.line_low) begin
                     if (tx_remaining_ff != '0) begin
                        result.tx_valid = 1'b1;
                        result.tx_data  = reply_byte;
                        running_sum_in  = running_sum_ff + reply_byte;
                        tx_pointer_in   = tx_pointer_ff + LENGTH_W'(1);
                        tx_remaining_in = tx_remaining_ff - LENGTH_W'(1);
                     end
                     if (tx_remaining_in == '0) begin
                        send_pending_in     = 1'b0;
                        phase_in            = trailer_wanted_ff ? PH_TRAILER : PH_IDLE;
                        result.line_release = 1'b1;
                     end
                  end
               end
               PH_TRAILER: begin
                  if (!item.line_low) begin
                     result.tx_valid     = 1'b1;
                     result.tx_data      = ~running_sum_ff;
                     result.line_release = 1'b1;
                     trailer_wanted_in   = 1'b0;
                     running_sum_in      = '0;
                     phase_in            = PH_IDLE;
                  end
               end
               PH_ERRWAIT: begin
                  if (error_wait_ff != '0) begin
                     error_wait_in = error_wait_ff - WAIT_W'(1);
                  end else begin
                     status_code_in    = ST_ERROR;
                     status_pending_in = 1'b1;
                     phase_in          = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
         KIND_SEND: begin
            if (!send_pending_ff && (phase_ff != PH_TRAILER) &&
                (item.send_length != '0) && (item.send_length <= REPLY_LIMIT)) begin
               tx_remaining_in      = item.send_length;
               trailer_wanted_in    = item.send_with_checksum;
               send_pending_in      = 1'b1;
               result.send_accepted = 1'b1;
            end
         end
         KIND_FREE: begin
            status_pending_in = 1'b0;
         end
         KIND_READ: begin
            result.read_data = read_byte;
         end
         default: begin
         end
      endcase

      // status and busy reflect the state after this request
      result.cmd_status = status_pending_in ? status_code_in : ST_NONE;
      result.send_busy  = (phase_in == PH_DATA) || (phase_in == PH_TRAILER);
   end

   // link state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         expected_length_ff <= '0;
         running_sum_ff     <= '0;
         rx_count_ff        <= '0;
         tx_pointer_ff      <= '0;
         tx_remaining_ff    <= '0;
         error_wait_ff      <= '0;
         status_code_ff     <= ST_NONE;
         previous_opcode_ff <= '0;
         send_pending_ff    <= 1'b0;
         trailer_wanted_ff  <= 1'b0;
         status_pending_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff           <= phase_in;
         expected_length_ff <= expected_length_in;
         running_sum_ff     <= running_sum_in;
         rx_count_ff        <= rx_count_in;
         tx_pointer_ff      <= tx_pointer_in;
         tx_remaining_ff    <= tx_remaining_in;
         error_wait_ff      <= error_wait_in;
         status_code_ff     <= status_code_in;
         previous_opcode_ff <= previous_opcode_in;
         send_pending_ff    <= send_pending_in;
         trailer_wanted_ff  <= trailer_wanted_in;
         status_pending_ff  <= status_pending_in;
      end
   end

   // command buffer, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CMD_DEPTH; i++) begin
            command_ff[i] <= '0;
         end
      end else if (fire && cmd_we) begin
         command_ff[cmd_waddr] <= cmd_wdata;
      end
   end

   // reply buffer, no reset
   always_ff @(posedge clock) begin
      if (fire && reply_we) begin
         reply_ff[item.index[RIDX_W-1:0]] <= item.tx_byte;
      end
   end

endmodule

### bench/serial_command_link_controller_tb.sv
// ----------------------------------------------------------------------------
// serial_command_link_controller_tb: request/result check of the link engine
// Drives a table of directed requests and then random receive, reply and
// noise sequences through the request channel, with random gaps and result
// stalls. Every result is compared field by field against the expected result
// of a typed directed row, or else against a behavioral model of the link in the bench.
// ----------------------------------------------------------------------------
module serial_command_link_controller_tb;
   import scl_pkg::*;

   localparam int CMD_DEPTH        = 12;
   localparam int REPLY_DEPTH      = 16;
   localparam int ERROR_WAIT_TICKS = 128;
   localparam int RANDOM_ITEMS     = 500;
   localparam int CALM_FROM        = 420;
   localparam int QUIET_LIMIT      = 500;

   // request kinds the block ignores
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

   // command length by opcode low nibble, opcode included
   localparam logic [COUNT_W-1:0] CMD_LEN [16] = '{
      4'd1, 4'd2, 4'd1, 4'd1, 4'd12, 4'd2, 4'd1, 4'd1,
      4'd4, 4'd1, 4'd1, 4'd1, 4'd1,  4'd2, 4'd1, 4'd1
   };

   localparam scl_rsp_type QUIET    = '0;
   localparam scl_rsp_type ERR_SEEN = '{1'b0, 8'h00, 1'b0, ST_ERROR, 8'h00, 1'b0, 1'b0};

   typedef struct packed {
      scl_req_type req;
      logic [7:0]  reps;
      logic        typed;
      scl_rsp_type want;
   } stim_row_type;

   // directed requests: typed rows carry their own expected result
   localparam int DIRECTED_ROWS = 29;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // fresh command buffer reads zero, also out of range
      '{'{KIND_READ, 1'b0, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b1, QUIET},
      '{'{KIND_READ, 1'b0, 8'h00, 4'hF, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b1, QUIET},
      // bad send lengths
      '{'{KIND_SEND, 1'b0, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b1, QUIET},
      '{'{KIND_SEND, 1'b0, 8'h00, 4'h0, 8'h00, 5'd17, 1'b1}, 8'd1,   1'b1, QUIET},
      '{'{KIND_SEND, 1'b0, 8'h00, 4'h0, 8'h00, 5'd31, 1'b1}, 8'd1,   1'b1, QUIET},
      // unknown kinds with every field at its top
      '{'{KIND_UNUSED_LO, 1'b1, 8'hFF, 4'hF, 8'hFF, 5'd31, 1'b1}, 8'd1, 1'b1, QUIET},
      '{'{KIND_UNUSED_HI, 1'b1, 8'hFF, 4'hF, 8'hFF, 5'd31, 1'b1}, 8'd1, 1'b1, QUIET},
      // idle with line high, then opcode zero and the error wait
      '{'{KIND_TICK, 1'b0, 8'hFF, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b1, QUIET},
      '{'{KIND_TICK, 1'b1, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b1, QUIET},
      '{'{KIND_TICK, 1'b0, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b1, QUIET},
      '{'{KIND_TICK, 1'b0, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd128, 1'b1, QUIET},
      '{'{KIND_TICK, 1'b0, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b1, ERR_SEEN},
      '{'{KIND_FREE, 1'b0, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b1, QUIET},
      // two byte command with a line high wait, good checksum
      '{'{KIND_TICK, 1'b1, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_TICK, 1'b1, 8'h11, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_TICK, 1'b0, 8'h55, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_TICK, 1'b1, 8'h22, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_TICK, 1'b1, 8'hCC, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_READ, 1'b0, 8'h00, 4'h1, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      // one byte command with a bad checksum
      '{'{KIND_TICK, 1'b1, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_TICK, 1'b1, 8'h03, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_TICK, 1'b1, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      // full length reply with trailer, second send refused while pending
      '{'{KIND_LOAD, 1'b0, 8'h00, 4'hF, 8'hFF, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_LOAD, 1'b0, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_SEND, 1'b0, 8'h00, 4'h0, 8'h00, 5'd16, 1'b1}, 8'd1,   1'b0, QUIET},
      '{'{KIND_SEND, 1'b0, 8'h00, 4'h0, 8'h00, 5'd1,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_TICK, 1'b0, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_TICK, 1'b1, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd1,   1'b0, QUIET},
      '{'{KIND_TICK, 1'b0, 8'h00, 4'h0, 8'h00, 5'd0,  1'b0}, 8'd17,  1'b0, QUIET}
   };

   logic clock = 1'b0;
   logic reset;

   scl_req_if req_bus ();
   scl_rsp_if rsp_bus ();

   serial_command_link_controller #(
      .CMD_DEPTH        (CMD_DEPTH),
      .REPLY_DEPTH      (REPLY_DEPTH),
      .ERROR_WAIT_TICKS (ERROR_WAIT_TICKS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // link model state
   logic [PHASE_W-1:0]  link_phase     = PH_IDLE;
   logic [COUNT_W-1:0]  want_len       = '0;
   logic [BYTE_W-1:0]   link_sum       = '0;
   logic [COUNT_W-1:0]  rx_cnt         = '0;
   logic [4:0]          tx_ptr         = '0;
   logic [4:0]          tx_left        = '0;
   logic [WAIT_W-1:0]   err_wait       = '0;
   logic [STATUS_W-1:0] status_code    = ST_NONE;
   logic [BYTE_W-1:0]   last_opcode    = '0;
   logic [BYTE_W-1:0]   cmd_mem [CMD_DEPTH]   = '{default: '0};
   logic [BYTE_W-1:0]   reply_mem [REPLY_DEPTH] = '{default: '0};
   logic                send_pending   = 1'b0;
   logic                trailer_on     = 1'b0;
   logic                status_valid   = 1'b0;

   scl_rsp_type link_results_due [$];
   int unsigned mismatch_count = 0;
   int unsigned results_seen   = 0;
   int unsigned random_items   = 0;
   bit          in_random_part = 1'b0;
   int unsigned req_gap_odds   = 0;
   int unsigned rsp_stall_odds = 0;
   int unsigned stall_left     = 0;
   int unsigned quiet_cycles   = 0;

   // one request through the link model, result as the block should give it
   function automatic scl_rsp_type link_predict(input scl_req_type r);
      scl_rsp_type o;
      logic [BYTE_W-1:0] b;
      o = '0;
      case (r.kind)
         KIND_TICK: begin
            case (link_phase)
               PH_IDLE: begin
                  if (send_pending) begin
                     tx_ptr = '0;
                     link_sum = '0;
                     link_phase = PH_DATA;
                  end else if (r.line_low) begin
                     rx_cnt = '0;
                     link_sum = '0;
                     link_phase = PH_OPCODE;
                  end
               end
               PH_OPCODE: begin
                  if (r.rx_byte == 8'h00) begin
                     err_wait = WAIT_W'(ERROR_WAIT_TICKS);
                     link_phase = PH_ERRWAIT;
                  end else begin
                     cmd_mem[0] = r.rx_byte;
                     link_sum = r.rx_byte;
                     rx_cnt = 4'd1;
                     want_len = CMD_LEN[r.rx_byte[3:0]];
                     link_phase = (want_len <= 4'd1) ? PH_CHECK : PH_PARAM;
                  end
               end
               PH_PARAM: begin
                  if (r.line_low) begin
                     if (rx_cnt < CMD_DEPTH) cmd_mem[rx_cnt] = r.rx_byte;
                     link_sum = link_sum + r.rx_byte;
                     rx_cnt = rx_cnt + 4'd1;
                     if (rx_cnt >= want_len) link_phase = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  if (r.line_low) begin
                     // inverted sum decides good or bad, opcode decides new or same
                     if (8'(~r.rx_byte) == link_sum) begin
                        if (cmd_mem[0] == last_opcode) begin
                           status_code = ST_SAME;
                        end else begin
                           status_code = ST_NEW;
                           last_opcode = cmd_mem[0];
                        end
                     end else begin
                        status_code = ST_ERROR;
                        last_opcode = '0;
                     end
                     status_valid = 1'b1;
                     link_sum = '0;
                     link_phase = PH_IDLE;
                  end
               end
               PH_DATA: begin
                  if (!r.line_low) begin
                     if (tx_left != 0) begin
                        b = (tx_ptr < REPLY_DEPTH) ? reply_mem[tx_ptr[3:0]] : 8'h00;
                        o.tx_valid = 1'b1;
                        o.tx_data = b;
                        link_sum = link_sum + b;
                        tx_ptr = tx_ptr + 5'd1;
                        tx_left = tx_left - 5'd1;
                     end
                     if (tx_left == 0) begin
                        send_pending = 1'b0;
                        link_phase = trailer_on ? PH_TRAILER : PH_IDLE;
                        o.line_release = 1'b1;
                     end
                  end
               end
               PH_TRAILER: begin
                  if (!r.line_low) begin
                     o.tx_valid = 1'b1;
                     o.tx_data = ~link_sum;
                     trailer_on = 1'b0;
                     link_sum = '0;
                     link_phase = PH_IDLE;
                     o.line_release = 1'b1;
                  end
               end
               PH_ERRWAIT: begin
                  if (err_wait > 0) begin
                     err_wait = err_wait - 8'd1;
                  end else begin
                     status_code = ST_ERROR;
                     status_valid = 1'b1;
                     link_phase = PH_IDLE;
                  end
               end
               default: begin
                  link_phase = PH_IDLE;
               end
            endcase
         end
         KIND_LOAD: begin
            if (r.index < REPLY_DEPTH) reply_mem[r.index] = r.tx_byte;
         end
         KIND_SEND: begin
            if (!send_pending && link_phase != PH_TRAILER && r.send_length != 0 &&
                r.send_length <= REPLY_DEPTH) begin
               tx_left = r.send_length;
               trailer_on = r.send_with_checksum;
               send_pending = 1'b1;
               o.send_accepted = 1'b1;
            end
         end
         KIND_FREE: begin
            status_valid = 1'b0;
         end
         KIND_READ: begin
            o.read_data = (r.index < CMD_DEPTH) ? cmd_mem[r.index] : 8'h00;
         end
         default: begin
         end
      endcase
      o.cmd_status = status_valid ? status_code : ST_NONE;
      o.send_busy = (link_phase == PH_DATA || link_phase == PH_TRAILER);
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("result %0d: %s", results_seen, msg);
      mismatch_count++;
   endtask

   task automatic check_result(input scl_rsp_type got, input scl_rsp_type want);
      if (got.tx_valid !== want.tx_valid)
         report_mismatch($sformatf("tx_valid %0h, expected %0h", got.tx_valid, want.tx_valid));
      if (got.tx_data !== want.tx_data)
         report_mismatch($sformatf("tx_data %0h, expected %0h", got.tx_data, want.tx_data));
      if (got.line_release !== want.line_release)
         report_mismatch($sformatf("line_release %0h, expected %0h",
                                   got.line_release, want.line_release));
      if (got.cmd_status !== want.cmd_status)
         report_mismatch($sformatf("cmd_status %0h, expected %0h",
                                   got.cmd_status, want.cmd_status));
      if (got.read_data !== want.read_data)
         report_mismatch($sformatf("read_data %0h, expected %0h", got.read_data, want.read_data));
      if (got.send_accepted !== want.send_accepted)
         report_mismatch($sformatf("send_accepted %0h, expected %0h",
                                   got.send_accepted, want.send_accepted));
      if (got.send_busy !== want.send_busy)
         report_mismatch($sformatf("send_busy %0h, expected %0h", got.send_busy, want.send_busy));
   endtask

   // request with every field random, kind given
   function automatic scl_req_type fresh_request(input logic [KIND_W-1:0] k);
      scl_req_type r;
      r.kind = k;
      r.line_low = 1'($urandom_range(0, 1));
      r.rx_byte = 8'($urandom_range(0, 255));
      r.index = 4'($urandom_range(0, 15));
      r.tx_byte = 8'($urandom_range(0, 255));
      r.send_length = 5'($urandom_range(0, 31));
      r.send_with_checksum = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // offer one request, wait for the handshake, then queue its expected result
   task automatic drive_request(input scl_req_type r, input bit typed,
                                input scl_rsp_type want);
      scl_rsp_type predicted;
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid              <= 1'b1;
      req_bus.kind               <= r.kind;
      req_bus.line_low           <= r.line_low;
      req_bus.rx_byte            <= r.rx_byte;
      req_bus.index              <= r.index;
      req_bus.tx_byte            <= r.tx_byte;
      req_bus.send_length        <= r.send_length;
      req_bus.send_with_checksum <= r.send_with_checksum;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = link_predict(r);
      link_results_due.push_back(typed ? want : predicted);
      if (in_random_part && r.kind <= KIND_READ) random_items++;
   endtask

   task automatic line_tick(input logic low, input logic [BYTE_W-1:0] rxb);
      scl_req_type r;
      r = fresh_request(KIND_TICK);
      r.line_low = low;
      r.rx_byte = rxb;
      drive_request(r, 1'b0, QUIET);
   endtask

   // tick until the link is idle with nothing queued, optionally meddling with
   // reply loads and send requests while a reply goes out
   task automatic run_link_until_idle(input bit meddle);
      int unsigned pick;
      logic low;
      while (link_phase != PH_IDLE || send_pending) begin
         pick = $urandom_range(0, 19);
         if (meddle && pick < 2) begin
            drive_request(fresh_request(KIND_LOAD), 1'b0, QUIET);
         end else if (meddle && pick == 2) begin
            drive_request(fresh_request(KIND_SEND), 1'b0, QUIET);
         end else begin
            if (link_phase == PH_OPCODE || link_phase == PH_PARAM || link_phase == PH_CHECK)
               low = 1'b1;
            else if (link_phase == PH_DATA || link_phase == PH_TRAILER)
               low = ($urandom_range(0, 4) == 0);
            else
               low = ($urandom_range(0, 5) == 0);
            line_tick(low, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // occasional line high sample inside a command
   task automatic hold_line();
      if ($urandom_range(0, 4) == 0) line_tick(1'b0, 8'($urandom_range(0, 255)));
   endtask

   // one command on the line, mostly well formed
   task automatic receive_command();
      logic [BYTE_W-1:0] opcode;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      int unsigned pick;
      run_link_until_idle(1'b0);
      pick = $urandom_range(0, 49);
      if (pick == 0)
         opcode = 8'h00;
      else if (pick < 15 && last_opcode != 0)
         opcode = last_opcode;
      else
         opcode = 8'($urandom_range(1, 255));
      line_tick(1'b1, 8'($urandom_range(0, 255)));
      line_tick(1'($urandom_range(0, 1)), opcode);
      if (opcode != 0) begin
         sum = opcode;
         for (int i = 1; i < CMD_LEN[opcode[3:0]]; i++) begin
            hold_line();
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            line_tick(1'b1, b);
         end
         hold_line();
         line_tick(1'b1, ($urandom_range(0, 6) != 0) ? ~sum : 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 2) == 0) drive_request(fresh_request(KIND_FREE), 1'b0, QUIET);
         if ($urandom_range(0, 4) < 2)
            repeat ($urandom_range(1, 3)) drive_request(fresh_request(KIND_READ), 1'b0, QUIET);
      end
   endtask

   // up to three loads, one send request, then the reply going out
   task automatic transmit_reply();
      scl_req_type r;
      run_link_until_idle(1'b0);
      repeat ($urandom_range(0, 3)) drive_request(fresh_request(KIND_LOAD), 1'b0, QUIET);
      r = fresh_request(KIND_SEND);
      case ($urandom_range(0, 9))
         0:       r.send_length = 5'($urandom_range(0, 31));
         1, 2:    r.send_length = 5'($urandom_range(1, REPLY_DEPTH));
         default: r.send_length = 5'($urandom_range(1, 4));
      endcase
      drive_request(r, 1'b0, QUIET);
      run_link_until_idle(1'b1);
   endtask

   // result ready with random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      scl_rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.tx_valid, rsp_bus.tx_data, rsp_bus.line_release, rsp_bus.cmd_status,
                 rsp_bus.read_data, rsp_bus.send_accepted, rsp_bus.send_busy};
         if (link_results_due.size() == 0)
            report_mismatch("result with no request outstanding");
         else
            check_result(got, link_results_due.pop_front());
         results_seen++;
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      scl_req_type r;
      int unsigned pick;
      reset                      <= 1'b1;
      req_bus.valid              <= 1'b0;
      req_bus.kind               <= KIND_TICK;
      req_bus.line_low           <= 1'b0;
      req_bus.rx_byte            <= '0;
      req_bus.index              <= '0;
      req_bus.tx_byte            <= '0;
      req_bus.send_length        <= '0;
      req_bus.send_with_checksum <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // fill every reply slot so no send reads an unwritten one
      req_gap_odds = 4;
      rsp_stall_odds = 4;
      for (int s = 0; s < REPLY_DEPTH; s++) begin
         r = fresh_request(KIND_LOAD);
         r.index = 4'(s);
         drive_request(r, 1'b0, QUIET);
      end

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++)
         repeat (DIRECTED[i].reps)
            drive_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

      // random sequences, calm toward the end
      in_random_part = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= CALM_FROM) begin
            req_gap_odds = 0;
            rsp_stall_odds = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  req_gap_odds = 0;
                  rsp_stall_odds = 0;
               end
               1: begin
                  req_gap_odds = 3;
                  rsp_stall_odds = 0;
               end
               2: begin
                  req_gap_odds = 0;
                  rsp_stall_odds = 3;
               end
               default: begin
                  req_gap_odds = 6;
                  rsp_stall_odds = 6;
               end
            endcase
         end
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            receive_command();
         end else if (pick < 8) begin
            transmit_reply();
         end else begin
            repeat ($urandom_range(1, 6))
               drive_request(fresh_request(KIND_W'($urandom_range(0, 7))), 1'b0, QUIET);
         end
      end

      // drain outstanding results
      req_bus.valid <= 1'b0;
      while (link_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
